// ----- rtl/ldrc_pkg.sv -----
// Shared types and constants for the LIN diagnostic response checker.
// Used by every module of the block; depends on nothing.
`default_nettype none
package ldrc_pkg;

   // Input command codes as they arrive on the request channel
   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_BYTE  = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   // Classified request kinds carried through the queue
   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_BYTE  = 2'd1,
      KIND_TICK  = 2'd2
   } kind_type;

   // Outcome codes reported on the response channel
   typedef enum logic [1:0] {
      RESP_POS     = 2'd0,
      RESP_NEG     = 2'd1,
      RESP_PEND    = 2'd2,
      RESP_TIMEOUT = 2'd3
   } resp_type;

   // Configuration register indexes
   localparam logic [1:0] CSR_TIMEOUT_TICKS = 2'd0;
   localparam logic [1:0] CSR_PEND_LIMIT    = 2'd1;

   localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd200;
   localparam logic [7:0]  PEND_LIMIT_RESET    = 8'd10;

   // Protocol byte values
   localparam logic [7:0] NEG_RSP_SID      = 8'h7F;
   localparam logic [7:0] NRC_PENDING      = 8'h78;
   localparam logic [7:0] SID_POS_OFFSET   = 8'h40;
   localparam logic [7:0] SID_POS_ALT      = 8'hF2;
   localparam logic [3:0] PCI_SINGLE       = 4'h0;
   localparam logic [3:0] PCI_FIRST        = 4'h1;
   localparam logic [3:0] PCI_CONSECUTIVE  = 4'h2;
   localparam logic [3:0] CHECKSUM_POS     = 4'd8;
   localparam logic [12:0] FF_PAYLOAD_LEN  = 13'd5;
   localparam logic [12:0] CF_PAYLOAD_LEN  = 13'd6;
   localparam logic [12:0] COLLECTED_MAX   = 13'd8191;
   localparam logic [7:0]  FRAMES_MAX      = 8'd255;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // One classified request waiting between front and back
   typedef struct packed {
      kind_type   kind;
      logic [7:0] value;   // service id on start, bus byte otherwise
   } entry_type;

   typedef struct packed {
      logic [15:0] timeout_ticks;
      logic [7:0]  pend_limit;
   } cfg_type;

endpackage
`default_nettype wire

// ----- rtl/ldrc_queue.sv -----
// Small FIFO that decouples request intake from transaction processing.
// Depends on ldrc_pkg for the entry type.
`default_nettype none
module ldrc_queue
   import ldrc_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  entry_type      push_entry,
   output logic           full,
   input  wire logic      pop,
   output logic           head_valid,
   output entry_type      head_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/ldrc_front.sv -----
// Request intake: takes requests, classifies the command and queues them.
// Depends on ldrc_pkg; instantiates ldrc_queue.
`default_nettype none
module ldrc_front
   import ldrc_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_cmd,
   input  wire logic [7:0] req_service_id,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       pop,
   output logic            head_valid,
   output entry_type       head_entry
);

   entry_type entry;
   logic      keep;
   logic      full;

   // Classify; reserved command codes are taken and dropped here
   always_comb begin
      entry.kind  = KIND_START;
      entry.value = req_rx_byte;
      keep        = 1'b1;
      unique case (cmd_type'(req_cmd))
         CMD_START: begin
            entry.kind  = KIND_START;
            entry.value = req_service_id;
         end
         CMD_BYTE: entry.kind = KIND_BYTE;
         CMD_TICK: entry.kind = KIND_TICK;
         default:  keep = 1'b0;
      endcase
   end

   assign req_stall = full;

   ldrc_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid && keep),
      .push_entry (entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

endmodule
`default_nettype wire

// ----- rtl/ldrc_back.sv -----
// Transaction engine: frame assembly, checksum, PCI classification and
// the registered response stage. Depends on ldrc_pkg.
`default_nettype none
module ldrc_back
   import ldrc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  cfg_type          cfg,
   input  wire logic        head_valid,
   input  entry_type        head_entry,
   output logic             pop,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_response_type,
   output logic [7:0]       rsp_frame_count,
   output logic [11:0]      rsp_total_length
);

   logic        busy_ff, busy_in;
   logic [7:0]  sid_ff, sid_in;
   logic [3:0]  pos_ff, pos_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  head_ff [4];
   logic [7:0]  head_in [4];
   logic [11:0] total_ff, total_in;
   logic [12:0] collected_ff, collected_in;
   logic [7:0]  pending_ff, pending_in;
   logic        multi_ff, multi_in;
   resp_type    type_ff, type_in;
   logic [15:0] idle_ff, idle_in;
   logic [7:0]  good_ff, good_in;

   logic        rsp_valid_ff, rsp_valid_in;
   resp_type    rsp_type_ff, rsp_type_in;
   logic [7:0]  rsp_count_ff, rsp_count_in;
   logic [11:0] rsp_total_ff, rsp_total_in;

   logic        out_free, go, done;
   resp_type    done_type, ff_type;
   logic [16:0] tick_next;
   logic [8:0]  sum_wide, pend_next;
   logic [13:0] col_wide;
   logic [12:0] col_sat;
   logic [11:0] ff_total;
   logic [7:0]  b;

   function automatic logic sid_positive(input logic [7:0] rs, input logic [7:0] sid);
      return (rs == sid + SID_POS_OFFSET) || (rs == SID_POS_ALT);
   endfunction

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign go       = head_valid && out_free;
   assign pop      = go;
   assign b        = head_entry.value;

   assign tick_next = {1'b0, idle_ff} + 17'd1;
   assign sum_wide  = {1'b0, sum_ff} + {1'b0, b};
   assign pend_next = {1'b0, pending_ff} + 9'd1;
   assign col_wide  = {1'b0, collected_ff} + {1'b0, CF_PAYLOAD_LEN};
   assign col_sat   = (col_wide > {1'b0, COLLECTED_MAX}) ? COLLECTED_MAX : col_wide[12:0];
   assign ff_total  = {head_ff[0][3:0], head_ff[1]};

   always_comb begin
      if (sid_positive(head_ff[2], sid_ff)) begin
         ff_type = RESP_POS;
      end else if (head_ff[2] == NEG_RSP_SID) begin
         ff_type = RESP_NEG;
      end else begin
         ff_type = type_ff;
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      sid_in       = sid_ff;
      pos_in       = pos_ff;
      sum_in       = sum_ff;
      head_in      = head_ff;
      total_in     = total_ff;
      collected_in = collected_ff;
      pending_in   = pending_ff;
      multi_in     = multi_ff;
      type_in      = type_ff;
      idle_in      = idle_ff;
      good_in      = good_ff;
      done         = 1'b0;
      done_type    = RESP_TIMEOUT;

      if (go) begin
         unique case (head_entry.kind)
            KIND_START: begin
               busy_in      = 1'b1;
               sid_in       = b;
               pos_in       = '0;
               sum_in       = '0;
               total_in     = '0;
               collected_in = '0;
               pending_in   = '0;
               multi_in     = 1'b0;
               type_in      = RESP_TIMEOUT;
               idle_in      = '0;
               good_in      = '0;
            end
            KIND_TICK: begin
               if (busy_ff) begin
                  if (tick_next > {1'b0, cfg.timeout_ticks}) begin
                     done = 1'b1;
                  end else begin
                     idle_in = tick_next[15:0];
                  end
               end
            end
            KIND_BYTE: begin
               if (busy_ff) begin
                  idle_in = '0;
                  if (pos_ff != CHECKSUM_POS) begin
                     // Frame body: capture head bytes, advance the carry-around sum
                     if (pos_ff >= 4'd1 && pos_ff <= 4'd4) begin
                        head_in[2'(pos_ff - 4'd1)] = b;
                     end
                     sum_in = (sum_wide > 9'd255) ? 8'(sum_wide - 9'd255) : sum_wide[7:0];
                     pos_in = pos_ff + 4'd1;
                  end else begin
                     pos_in = '0;
                     sum_in = '0;
                     if (~sum_ff != b) begin
                        done = 1'b1;
                     end else begin
                        if (good_ff != FRAMES_MAX) begin
                           good_in = good_ff + 8'd1;
                        end
                        case (head_ff[0][7:4])
                           PCI_SINGLE: begin
                              if (head_ff[1] == NEG_RSP_SID) begin
                                 if (head_ff[3] == NRC_PENDING) begin
                                    if (pend_next <= {1'b0, cfg.pend_limit}) begin
                                       pending_in = pend_next[7:0];
                                    end else begin
                                       done      = 1'b1;
                                       done_type = RESP_PEND;
                                    end
                                 end else begin
                                    done      = 1'b1;
                                    done_type = RESP_NEG;
                                 end
                              end else if (sid_positive(head_ff[1], sid_ff)) begin
                                 done      = 1'b1;
                                 done_type = RESP_POS;
                              end else begin
                                 done = 1'b1;
                              end
                           end
                           PCI_FIRST: begin
                              multi_in     = 1'b1;
                              total_in     = ff_total;
                              collected_in = FF_PAYLOAD_LEN;
                              type_in      = ff_type;
                              if (FF_PAYLOAD_LEN >= {1'b0, ff_total}) begin
                                 done      = 1'b1;
                                 done_type = ff_type;
                              end
                           end
                           PCI_CONSECUTIVE: begin
                              collected_in = col_sat;
                              if (multi_ff && col_sat >= {1'b0, total_ff}) begin
                                 done      = 1'b1;
                                 done_type = type_ff;
                              end
                           end
                           default: done = 1'b1;
                        endcase
                     end
                  end
               end
            end
            default: ;
         endcase
      end

      if (done) begin
         busy_in = 1'b0;
         type_in = done_type;
      end
   end

   // Response stage: load on a finish, hold while the consumer stalls
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_type_in  = rsp_type_ff;
      rsp_count_in = rsp_count_ff;
      rsp_total_in = rsp_total_ff;
      if (out_free) begin
         rsp_valid_in = done;
         if (done) begin
            rsp_type_in  = done_type;
            rsp_count_in = good_in;
            rsp_total_in = total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         sid_ff       <= '0;
         pos_ff       <= '0;
         sum_ff       <= '0;
         total_ff     <= '0;
         collected_ff <= '0;
         pending_ff   <= '0;
         multi_ff     <= 1'b0;
         type_ff      <= RESP_TIMEOUT;
         idle_ff      <= '0;
         good_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         sid_ff       <= sid_in;
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         total_ff     <= total_in;
         collected_ff <= collected_in;
         pending_ff   <= pending_in;
         multi_ff     <= multi_in;
         type_ff      <= type_in;
         idle_ff      <= idle_in;
         good_ff      <= good_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff      <= head_in;
      rsp_type_ff  <= rsp_type_in;
      rsp_count_ff <= rsp_count_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_response_type = rsp_type_ff;
   assign rsp_frame_count   = rsp_count_ff;
   assign rsp_total_length  = rsp_total_ff;

endmodule
`default_nettype wire

// ----- rtl/lin_diag_response_checker.sv -----
// Path: each request enters the request queue; the transaction engine takes it
//   from the queue head once the response stage is free; responses are registered.
// Throughput: one request per cycle while the response stage is free; the request
//   queue only fills while the response side stalls.
// Reset: synchronous, active high; clears queue, transaction state and response
//   stage and loads timeout_ticks = 200 and a pending limit of 10.
`default_nettype none
module lin_diag_response_checker
   import ldrc_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [7:0]  req_service_id,
   input  wire logic [7:0]  req_rx_byte,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_response_type,
   output logic [7:0]       rsp_frame_count,
   output logic [11:0]      rsp_total_length,
   // configuration write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   logic      pop;
   logic      head_valid;
   entry_type head_entry;

   // Writes are to be issued only while idle; not enforced, all are taken
   assign csr_ready = 1'b1;

   // Decode the register index; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TIMEOUT_TICKS: cfg_in.timeout_ticks = csr_wdata;
            CSR_PEND_LIMIT:    cfg_in.pend_limit    = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks <= TIMEOUT_TICKS_RESET;
         cfg_ff.pend_limit    <= PEND_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: classify, drop reserved codes, hold others until the engine pops them
   ldrc_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_service_id (req_service_id),
      .req_rx_byte    (req_rx_byte),
      .pop            (pop),
      .head_valid     (head_valid),
      .head_entry     (head_entry)
   );

   // Back: advance the transaction and register any outcome
   ldrc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .head_valid        (head_valid),
      .head_entry        (head_entry),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_response_type (rsp_response_type),
      .rsp_frame_count   (rsp_frame_count),
      .rsp_total_length  (rsp_total_length)
   );

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking bench for lin_diag_response_checker: drives starts, bus bytes and ticks,
// predicts every transaction outcome and compares it on the response channel.
// Depends on ldrc_pkg and the lin_diag_response_checker RTL.
`default_nettype none
module tb_top;
   import ldrc_pkg::*;

   // Index with no register behind it; writes there must change nothing
   localparam logic [1:0] CSR_UNMAPPED = 2'd2;
   localparam int PHASES = 7;
   localparam int HALF_PHASE_REQUESTS = 35;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] sid;
      logic [7:0] rx;
   } request_type;

   typedef struct packed {
      resp_type    rtype;
      logic [7:0]  frames;
      logic [11:0] length;
   } verdict_type;

   // DUT inputs, known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic [1:0]  req_cmd = 2'd0;
   logic [7:0]  req_service_id = 8'd0;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        rsp_stall = 1'b0;
   logic        csr_valid = 1'b0;
   logic [1:0]  csr_index = 2'd0;
   logic [15:0] csr_wdata = 16'd0;

   logic        req_stall;
   logic        rsp_valid;
   logic [1:0]  rsp_response_type;
   logic [7:0]  rsp_frame_count;
   logic [11:0] rsp_total_length;
   logic        csr_ready;

   lin_diag_response_checker DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_service_id    (req_service_id),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_response_type (rsp_response_type),
      .rsp_frame_count   (rsp_frame_count),
      .rsp_total_length  (rsp_total_length),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // Request stream waiting for the driver, and verdicts waiting for the monitor
   request_type pending_requests [$];
   verdict_type predicted_verdicts [$];
   request_type in_flight;
   int pushed_count = 0;
   int accepted_count = 0;
   int error_count = 0;
   int config_count = 0;
   int seen_by_type [4] = '{0, 0, 0, 0};

   // Predictor copy of the configuration
   logic [15:0] cfg_timeout = TIMEOUT_TICKS_RESET;
   logic [7:0]  cfg_max_pend = PEND_LIMIT_RESET;

   // Predictor copy of the transaction state
   logic        txn_busy;
   logic [7:0]  txn_sid;
   logic [3:0]  byte_pos;
   logic [8:0]  eac_sum;
   logic [7:0]  head [4];
   logic [11:0] want_total;
   logic [12:0] payload_seen;
   logic [7:0]  pending_cnt;
   logic        multi;
   resp_type    held_type;
   logic [15:0] idle_cnt;
   logic [7:0]  good_frames;

   // Driver pacing and receiver stall pattern
   int burst_left = 0;
   int gap_left = 0;
   int stall_mode = 0;
   int stall_left = 0;
   int stall_run = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Outcome prediction
   // ------------------------------------------------------------------

   // Positive echo: request sid plus 0x40 (wrapping), or the alternate code
   function automatic bit is_positive_echo(input logic [7:0] rs);
      return rs == 8'(txn_sid + SID_POS_OFFSET) || rs == SID_POS_ALT;
   endfunction

   // End the transaction and queue the verdict the block must report
   task automatic close_txn(input resp_type t);
      verdict_type v;
      v.rtype  = t;
      v.frames = good_frames;
      v.length = want_total;
      held_type = t;
      txn_busy = 1'b0;
      predicted_verdicts.push_back(v);
   endtask

   // Act on a frame whose checksum matched; head[] holds frame bytes 1..4
   task automatic decode_frame();
      case (head[0][7:4])
         PCI_SINGLE: begin
            if (head[1] == NEG_RSP_SID) begin
               // Negative response; the pending code keeps the transaction alive
               if (head[3] != NRC_PENDING) close_txn(RESP_NEG);
               else if ({1'b0, pending_cnt} + 9'd1 <= {1'b0, cfg_max_pend})
                  pending_cnt = pending_cnt + 8'd1;
               else close_txn(RESP_PEND);
            end else if (is_positive_echo(head[1])) begin
               close_txn(RESP_POS);
            end else begin
               close_txn(RESP_TIMEOUT);
            end
         end
         PCI_FIRST: begin
            multi = 1'b1;
            want_total = {head[0][3:0], head[1]};
            payload_seen = FF_PAYLOAD_LEN;
            // An unrecognized sid leaves the held type untouched
            if (is_positive_echo(head[2])) held_type = RESP_POS;
            else if (head[2] == NEG_RSP_SID) held_type = RESP_NEG;
            if (payload_seen >= {1'b0, want_total}) close_txn(held_type);
         end
         PCI_CONSECUTIVE: begin
            if (payload_seen > COLLECTED_MAX - CF_PAYLOAD_LEN) payload_seen = COLLECTED_MAX;
            else payload_seen = payload_seen + CF_PAYLOAD_LEN;
            // Without a first frame this only counts bytes
            if (multi && payload_seen >= {1'b0, want_total}) close_txn(held_type);
         end
         default: close_txn(RESP_TIMEOUT);
      endcase
   endtask

   // Advance the predicted state by one accepted request
   task automatic predict_verdict(input request_type r);
      logic [7:0] csum_want;
      if (r.cmd == CMD_START) begin
         // A start while busy silently drops the running transaction
         txn_busy = 1'b1;
         txn_sid = r.sid;
         byte_pos = '0;
         eac_sum = '0;
         want_total = '0;
         payload_seen = '0;
         pending_cnt = '0;
         multi = 1'b0;
         held_type = RESP_TIMEOUT;
         idle_cnt = '0;
         good_frames = '0;
      end else if (txn_busy && r.cmd == CMD_TICK) begin
         if ({1'b0, idle_cnt} + 17'd1 > {1'b0, cfg_timeout}) close_txn(RESP_TIMEOUT);
         else idle_cnt = idle_cnt + 16'd1;
      end else if (txn_busy && r.cmd == CMD_BYTE) begin
         idle_cnt = '0;
         if (byte_pos < CHECKSUM_POS) begin
            if (byte_pos >= 4'd1 && byte_pos <= 4'd4) head[2'(byte_pos - 4'd1)] = r.rx;
            eac_sum = eac_sum + r.rx;
            if (eac_sum > 9'd255) eac_sum = eac_sum - 9'd255;
            byte_pos = byte_pos + 4'd1;
         end else begin
            csum_want = ~eac_sum[7:0];
            byte_pos = '0;
            eac_sum = '0;
            if (csum_want != r.rx) begin
               close_txn(RESP_TIMEOUT);
            end else begin
               if (good_frames != FRAMES_MAX) good_frames = good_frames + 8'd1;
               decode_frame();
            end
         end
      end
      // Bytes and ticks while idle, and the no-op command, change nothing
   endtask

   // ------------------------------------------------------------------
   // Stimulus construction
   // ------------------------------------------------------------------

   // Queue one request; fields the command does not use carry random junk
   task automatic push_request(input cmd_type c, input logic [7:0] v);
      request_type r;
      r.cmd = c;
      r.sid = (c == CMD_START) ? v : 8'($urandom);
      r.rx  = (c == CMD_BYTE) ? v : 8'($urandom);
      pending_requests.push_back(r);
      pushed_count++;
   endtask

   // Sprinkle ticks between bytes, never enough to time out
   task automatic push_idle_ticks();
      int n;
      if (cfg_timeout != 0 && $urandom_range(0, 7) == 0) begin
         // Sometimes sit exactly on the limit
         if (cfg_timeout <= 6 && $urandom_range(0, 1) == 0) n = cfg_timeout;
         else n = $urandom_range(1, (cfg_timeout < 3) ? cfg_timeout : 3);
         repeat (n) push_request(CMD_TICK, 8'h00);
      end
   endtask

   // Classic end-around-carry checksum over the 8 data bytes, inverted
   function automatic logic [7:0] frame_checksum(input logic [63:0] f);
      logic [8:0] acc;
      acc = '0;
      for (int i = 0; i < 8; i++) begin
         acc = acc + f[63 - 8 * i -: 8];
         if (acc > 9'd255) acc = acc - 9'd255;
      end
      return ~acc[7:0];
   endfunction

   // Send 8 data bytes (byte 0 in the top bits) and the checksum, optionally corrupted
   task automatic push_frame(input logic [63:0] f, input bit corrupt);
      logic [7:0] csum;
      for (int i = 0; i < 8; i++) begin
         push_idle_ticks();
         push_request(CMD_BYTE, f[63 - 8 * i -: 8]);
      end
      push_idle_ticks();
      csum = frame_checksum(f);
      if (corrupt) csum = csum ^ 8'($urandom_range(1, 255));
      push_request(CMD_BYTE, csum);
   endtask

   function automatic logic [63:0] single_frame(input logic [7:0] rs, input logic [7:0] echo,
                                                input logic [7:0] code);
      return {8'($urandom), PCI_SINGLE, 4'($urandom), rs, echo, code, 8'($urandom),
              16'($urandom)};
   endfunction

   function automatic logic [63:0] first_frame(input logic [11:0] len, input logic [7:0] rs);
      return {8'($urandom), PCI_FIRST, len[11:8], len[7:0], rs, 32'($urandom)};
   endfunction

   function automatic logic [63:0] cons_frame();
      return {8'($urandom), PCI_CONSECUTIVE, 4'($urandom), 16'($urandom), 32'($urandom)};
   endfunction

   function automatic logic [7:0] positive_echo(input logic [7:0] sid);
      return ($urandom_range(0, 3) == 0) ? SID_POS_ALT : 8'(sid + SID_POS_OFFSET);
   endfunction

   // Exceed the tick limit; skip when the limit is too large to reach cheaply
   task automatic push_timeout();
      if (cfg_timeout <= 12) repeat (cfg_timeout + 1) push_request(CMD_TICK, 8'h00);
   endtask

   // One transaction: mostly well-formed exchanges, some broken ones
   task automatic add_transaction();
      logic [7:0]  sid;
      logic [7:0]  rs;
      logic [11:0] len;
      int kind;
      int n;
      bit truncated;
      sid = 8'($urandom);
      push_request(CMD_START, sid);
      kind = $urandom_range(0, 12);
      case (kind)
         0, 1: push_frame(single_frame(positive_echo(sid), sid, 8'($urandom)), 1'b0);
         2: push_frame(single_frame(NEG_RSP_SID, sid, 8'($urandom)), 1'b0);
         3, 4: begin
            // Response-pending chain, sometimes past the tolerated count
            n = $urandom_range(0, cfg_max_pend + 1);
            if (n > 6) n = $urandom_range(0, 6);
            repeat (n) push_frame(single_frame(NEG_RSP_SID, sid, NRC_PENDING), 1'b0);
            case ($urandom_range(0, 2))
               0: push_frame(single_frame(positive_echo(sid), sid, 8'($urandom)), 1'b0);
               1: push_frame(single_frame(NEG_RSP_SID, sid, 8'($urandom)), 1'b0);
               default: push_timeout();
            endcase
         end
         5, 6, 7: begin
            // Segmented response; long lengths are cut short and left to time out
            len = ($urandom_range(0, 7) == 0) ? 12'($urandom) : 12'($urandom_range(0, 40));
            case ($urandom_range(0, 3))
               0: rs = NEG_RSP_SID;
               1: rs = 8'($urandom);
               default: rs = positive_echo(sid);
            endcase
            push_frame(first_frame(len, rs), 1'b0);
            n = (len > 12'd5) ? int'(len) / 6 : 0;
            truncated = n > 8;
            if (truncated) n = $urandom_range(1, 4);
            repeat (n) push_frame(cons_frame(), $urandom_range(0, 30) == 0);
            if (truncated) push_timeout();
         end
         8: push_frame({8'($urandom), 4'($urandom_range(3, 15)), 4'($urandom),
                        16'($urandom), 32'($urandom)}, 1'b0);
         9: push_frame(single_frame(8'($urandom), sid, 8'($urandom)), 1'b0);
         10: begin
            // Consecutive frame ahead of any first frame
            push_frame(cons_frame(), 1'b0);
            push_frame(first_frame(12'($urandom_range(0, 17)), positive_echo(sid)), 1'b0);
            repeat (3) push_frame(cons_frame(), 1'b0);
         end
         11: push_frame(single_frame(positive_echo(sid), sid, 8'($urandom)), 1'b1);
         default: begin
            // Partial frame, then the bus goes quiet
            repeat ($urandom_range(0, 8)) push_request(CMD_BYTE, 8'($urandom));
            push_timeout();
         end
      endcase
      // Occasional noise: any command, any byte
      if ($urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 4))
            push_request(cmd_type'($urandom_range(0, 3)), 8'($urandom));
   endtask

   // Hold until every request is taken and every verdict has arrived,
   // then wait for the block to finish any resultless request
   task automatic wait_quiet();
      do @(posedge clock);
      while (accepted_count != pushed_count || predicted_verdicts.size() != 0);
      repeat (6) @(posedge clock);
   endtask

   // Write both registers (and maybe the unmapped index) back to back, valid held high
   task automatic write_config(input int t, input int m, input bit poke_unmapped);
      csr_valid <= 1'b1;
      csr_index <= CSR_TIMEOUT_TICKS;
      csr_wdata <= 16'(t);
      do @(posedge clock); while (!csr_ready);
      cfg_timeout = 16'(t);
      // Upper bits carry junk; only the low byte is the register
      csr_index <= CSR_PEND_LIMIT;
      csr_wdata <= {8'($urandom), 8'(m)};
      do @(posedge clock); while (!csr_ready);
      cfg_max_pend = 8'(m);
      if (poke_unmapped) begin
         csr_index <= CSR_UNMAPPED;
         csr_wdata <= 16'($urandom);
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      config_count++;
   endtask

   // ------------------------------------------------------------------
   // Request driver: bursts with random gaps; payload held while stalled
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         txn_busy = 1'b0;
         txn_sid = '0;
         byte_pos = '0;
         eac_sum = '0;
         want_total = '0;
         payload_seen = '0;
         pending_cnt = '0;
         multi = 1'b0;
         held_type = RESP_TIMEOUT;
         idle_cnt = '0;
         good_frames = '0;
         cfg_timeout = TIMEOUT_TICKS_RESET;
         cfg_max_pend = PEND_LIMIT_RESET;
      end else begin
         // Predict on acceptance, before the slot is refilled
         if (req_valid && !req_stall) begin
            predict_verdict(in_flight);
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               in_flight = pending_requests.pop_front();
               req_valid <= 1'b1;
               req_cmd <= in_flight.cmd;
               req_service_id <= in_flight.sid;
               req_rx_byte <= in_flight.rx;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  // New burst; a third of them follow on with no gap at all
                  burst_left = $urandom_range(0, 30);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Response stall pattern: free-running, stretches of random stalls,
   // long stall runs
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(20, 200);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 2) == 0);
         default: begin
            if (stall_run == 0) begin
               rsp_stall <= !rsp_stall;
               stall_run = $urandom_range(1, 15);
            end else begin
               stall_run--;
            end
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Response monitor: compare each accepted response with the oldest verdict
   // ------------------------------------------------------------------
   verdict_type oldest;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_by_type[rsp_response_type]++;
         if (predicted_verdicts.size() == 0) begin
            $error("unexpected response: type %0d frames %0d length %0d",
                   rsp_response_type, rsp_frame_count, rsp_total_length);
            error_count++;
         end else begin
            oldest = predicted_verdicts.pop_front();
            if (rsp_response_type !== oldest.rtype) begin
               $error("response_type: expected %0d, got %0d", oldest.rtype, rsp_response_type);
               error_count++;
            end
            if (rsp_frame_count !== oldest.frames) begin
               $error("frame_count: expected %0d, got %0d", oldest.frames, rsp_frame_count);
               error_count++;
            end
            if (rsp_total_length !== oldest.length) begin
               $error("total_length: expected %0d, got %0d", oldest.length, rsp_total_length);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   int phase_timeout [PHASES] = '{0, 1, 4, 65535, 200, 7, 2};
   int phase_pending [PHASES] = '{0, 1, 3, 255, 10, 20, 5};

   initial begin
      int t;
      int m;
      int base;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: idle commands, a clean positive reply with extreme bytes,
      // a no-op and tick while busy, a restart while busy, and a reply whose
      // sid wraps past 0xFF but whose checksum is broken
      push_request(CMD_BYTE, 8'hFF);
      push_request(CMD_TICK, 8'h00);
      push_request(CMD_NOP, 8'h00);
      push_request(CMD_START, 8'h22);
      push_frame({8'hFF, 8'h06, 8'h62, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00}, 1'b0);
      push_request(CMD_START, 8'hFF);
      push_request(CMD_NOP, 8'h55);
      push_request(CMD_TICK, 8'hAA);
      push_request(CMD_START, 8'hC0);
      push_frame({8'h3D, 8'h03, 8'h00, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55}, 1'b1);
      wait_quiet();

      // Random phases, one register setting each, drained at the midpoint too
      for (int p = 0; p < PHASES; p++) begin
         t = phase_timeout[p];
         m = phase_pending[p];
         if (p == 5) begin
            t = $urandom_range(1, 12);
            m = $urandom_range(0, 20);
         end
         write_config(t, m, p == 2);
         for (int half = 0; half < 2; half++) begin
            base = pushed_count;
            while (pushed_count - base < HALF_PHASE_REQUESTS) add_transaction();
            wait_quiet();
         end
      end

      $display("tb_top summary: %0d requests over %0d register settings", accepted_count,
               config_count);
      $display("tb_top summary: positive %0d, negative %0d, pending %0d, timeout %0d",
               seen_by_type[0], seen_by_type[1], seen_by_type[2], seen_by_type[3]);
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #10000000;
      $display("tb_top: errors");
      $finish;
   end

endmodule
`default_nettype wire

// ----- lin_diag_response_checker.f -----
rtl/ldrc_pkg.sv
rtl/ldrc_queue.sv
rtl/ldrc_front.sv
rtl/ldrc_back.sv
rtl/lin_diag_response_checker.sv
bench/tb_top.sv
